[rtl/core/spq_pkg.sv]
// spq_pkg: shared constants, status codes and types for the sorted priority queue.
// No dependencies; used by the queue cells, the top level and the port checker.
`default_nettype none

package spq_pkg;

   // Default number of cells in the chain
   localparam int DEPTH_DEFAULT = 16;

   // Field widths
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   // Operation codes
   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_ENQ   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DEQ   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;   // place the new item in sorted position
      logic remove;   // shift every entry one cell towards the tail
   } cell_ctrl_type;

endpackage

`default_nettype wire

[rtl/core/sorted_priority_queue.sv]
// Sorted priority queue: one item per cycle, result in the cycle after start, busy never high.
// Each cell compares itself with the broadcast item, so all cells update together in the same cycle.
// Throughput is one item per clock; the rsp_valid strobe is registered from acceptance.
// Synchronous active-high reset empties the queue and drops any pending result.
// Cell contents are not reset; only entries below the count are ever read.
// Depends on spq_pkg and spq_cell.
`default_nettype none

module sorted_priority_queue #(
   parameter int QUEUE_DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    start,
   output logic                                   busy,
   input  wire logic                              req_opcode,
   input  wire logic signed [spq_pkg::DATA_W-1:0] req_value,
   output logic                                   rsp_valid,
   output logic [spq_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [spq_pkg::DATA_W-1:0]      rsp_data_out,
   output logic [spq_pkg::OCC_W-1:0]              rsp_occupancy
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0]                  count_ff, count_in;
   logic                              rsp_valid_ff;
   logic [spq_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic signed [spq_pkg::DATA_W-1:0] data_ff, data_in;
   logic                              accept;
   logic                              full, empty;
   spq_pkg::cell_ctrl_type            ctrl;

   logic                              less   [QUEUE_DEPTH];
   logic signed [spq_pkg::DATA_W-1:0] values [QUEUE_DEPTH];

   // The chain has no multi-cycle work, so items are always taken
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);

   // Decode the command and the result of this item
   always_comb begin
      ctrl      = '0;
      count_in  = count_ff;
      status_in = status_ff;
      data_in   = data_ff;
      if (accept) begin
         data_in = '0;
         if (req_opcode == spq_pkg::OP_ENQ) begin
            if (full) begin
               status_in = spq_pkg::ST_FULL;
            end else begin
               ctrl.insert = 1'b1;
               count_in    = count_ff + CNT_W'(1);
               status_in   = spq_pkg::ST_ENQ;
            end
         end else begin
            if (empty) begin
               status_in = spq_pkg::ST_EMPTY;
            end else begin
               ctrl.remove = 1'b1;
               count_in    = count_ff - CNT_W'(1);
               status_in   = spq_pkg::ST_DEQ;
               data_in     = values[0];
            end
         end
      end
   end

   // Row of cells: cell 0 holds the smallest entry, ascending upward
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                              lower_less;
      logic signed [spq_pkg::DATA_W-1:0] lower_value;
      logic signed [spq_pkg::DATA_W-1:0] upper_value;

      if (i == 0) begin : g_tail
         assign lower_less  = 1'b1;
         assign lower_value = req_value;
      end else begin : g_mid
         assign lower_less  = less[i-1];
         assign lower_value = values[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_top
         assign upper_value = values[i];
      end else begin : g_below_top
         assign upper_value = values[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_value   (req_value),
         .occupied    (CNT_W'(i) < count_ff),
         .lower_less  (lower_less),
         .lower_value (lower_value),
         .upper_value (upper_value),
         .less        (less[i]),
         .value_ff    (values[i])
      );
   end

   // Hold count and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
      status_ff <= status_in;
      data_ff   <= data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_data_out  = data_ff;
   assign rsp_occupancy = spq_pkg::OCC_W'(count_ff);

endmodule

`default_nettype wire

[rtl/core/spq_cell.sv]
// spq_cell: one storage cell of the sorted chain.
// Depends on spq_pkg for the data width and the command struct.
`default_nettype none

module spq_cell (
   input  wire                                  clock,
   input  wire spq_pkg::cell_ctrl_type          ctrl,
   input  wire logic signed [spq_pkg::DATA_W-1:0] new_value,
   input  wire logic                            occupied,
   input  wire logic                            lower_less,
   input  wire logic signed [spq_pkg::DATA_W-1:0] lower_value,
   input  wire logic signed [spq_pkg::DATA_W-1:0] upper_value,
   output logic                                 less,
   output logic signed [spq_pkg::DATA_W-1:0]    value_ff
);

   logic signed [spq_pkg::DATA_W-1:0] value_in;

   // Flag entries strictly below the incoming item; these stay put on insert
   assign less = occupied && (value_ff < new_value);

   // Choose the next entry: hold, take the new item, or take a neighbour's
   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (!less) begin
            if (lower_less) begin
               value_in = new_value;
            end else begin
               value_in = lower_value;
            end
         end
      end else if (ctrl.remove) begin
         value_in = upper_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

[rtl/core/spq_checker.sv]
// spq_checker: port-level checks of the sorted priority queue over time.
// Depends on spq_pkg; bound to sorted_priority_queue at the end of this file.
`default_nettype none

module spq_checker (
   input wire                                    clock,
   input wire                                    reset,
   input wire                                    start,
   input wire                                    busy,
   input wire logic                              rsp_valid,
   input wire logic [spq_pkg::STATUS_W-1:0]      rsp_status,
   input wire logic signed [spq_pkg::DATA_W-1:0] rsp_data_out,
   input wire logic [spq_pkg::OCC_W-1:0]         rsp_occupancy
);

   // Every accepted item gives its result on the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted item gave no result");

   // No result appears without an accepted item
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("result without an accepted item");

   // Data is zero unless an item was dequeued
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != spq_pkg::ST_DEQ) |-> (rsp_data_out == '0))
      else $error("non-zero data on a non-dequeue result");

   // An empty refusal reports an empty queue
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == spq_pkg::ST_EMPTY) |-> (rsp_occupancy == '0))
      else $error("empty status with non-zero occupancy");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_status    (rsp_status),
   .rsp_data_out  (rsp_data_out),
   .rsp_occupancy (rsp_occupancy)
);

`default_nettype wire
